### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define CSOR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("csor assertion failed");

// Checked at every edge, reset included.
`define CSOR_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("csor assertion failed");

`endif

### src/csor_pkg.sv
package csor_pkg;

    typedef enum logic [6:0] {
        OP_w, OP_J, OP_j, OP_M, OP_MP, OP_d, OP_d0, OP_d1, OP_ri, OP_re, OP_rg,
        OP_i, OP_g, OP_gs, OP_q, OP_Q, OP_c, OP_cm, OP_cs, OP_m, OP_l, OP_v,
        OP_y, OP_h, OP_S, OP_SC, OP_SCN, OP_s, OP_sc, OP_scn, OP_sh, OP_f,
        OP_fstar, OP_F, OP_B, OP_Bstar, OP_BT, OP_BI, OP_BMC, OP_BDC, OP_BX,
        OP_b, OP_bstar, OP_n, OP_W, OP_Wstar, OP_ET, OP_EI, OP_EMC, OP_EX,
        OP_Tc, OP_Tw, OP_Tz, OP_TL, OP_Tf, OP_Tr, OP_Ts, OP_Td, OP_TD, OP_Tm,
        OP_Tstar, OP_Tj, OP_TJ, OP_squote, OP_dquote, OP_CS, OP_G, OP_RG, OP_K,
        OP_k, OP_ID, OP_Do, OP_DP
    } t_op;

    typedef enum logic [4:0] {
        PS_IDLE, PS_M, PS_d, PS_r, PS_g, PS_c, PS_S, PS_SC, PS_s, PS_sc, PS_f,
        PS_B, PS_BM, PS_BD, PS_b, PS_W, PS_E, PS_EM, PS_T, PS_C, PS_R, PS_I, PS_D
    } t_pstate;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_UNKNOWN = 2'd1;
    localparam t_status ST_EOD     = 2'd2;

    localparam int unsigned OP_W_BITS = 7;

endpackage

### src/content_stream_operator_recognizer_core.sv
// Channel  | Dir | tdata                  | tuser
// s_axis   | in  | [7:0] in_byte          | end_of_data
// m_axis   | out | [6:0] op_code, [7] 0   | [1:0] status, [2] byte_used
//
// One transfer per cycle sustained while m_axis is not stalled; a result is registered after the input register.
// Input register -> one level of prefix-tree decode -> result register.
// i_rst_n (sync, active low) clears valids and returns the prefix state to idle.
// A stalled m_axis holds only items that produce a result; others still drain.
module content_stream_operator_recognizer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tuser,   // [0] end_of_data
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] op_code, [7] zero
    output logic [2:0] m_axis_tuser    // [1:0] status, [2] byte_used
);
    import csor_pkg::*;

    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         r_in_eod;
    t_pstate      r_state;
    logic         r_out_valid;
    t_op          r_out_op;
    t_status      r_out_status;
    logic         r_out_used;

    logic         ends;
    logic         d_emit;
    t_op          d_op;
    t_status      d_status;
    logic         d_used;
    t_pstate      n_state;
    logic         out_free;
    logic         proc;

    function automatic logic is_sep(input logic [7:0] ch);
        case (ch)
            8'h00, 8'h09, 8'h0A, 8'h0C, 8'h0D, 8'h20,
            "(", ")", "<", ">", "[", "]", "{", "}", "/", "%": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    always_comb begin
        ends     = r_in_eod || is_sep(r_in_byte);
        d_emit   = 1'b0;
        d_op     = OP_w;
        d_status = ST_OK;
        d_used   = 1'b0;
        n_state  = r_state;
        case (r_state)
            PS_IDLE: begin
                if (!r_in_eod) begin
                    d_emit = 1'b1;
                    d_used = 1'b1;
                    case (r_in_byte)
                        "w":  d_op = OP_w;
                        "J":  d_op = OP_J;
                        "j":  d_op = OP_j;
                        "i":  d_op = OP_i;
                        "q":  d_op = OP_q;
                        "Q":  d_op = OP_Q;
                        "m":  d_op = OP_m;
                        "l":  d_op = OP_l;
                        "v":  d_op = OP_v;
                        "y":  d_op = OP_y;
                        "h":  d_op = OP_h;
                        "F":  d_op = OP_F;
                        "n":  d_op = OP_n;
                        "'":  d_op = OP_squote;
                        "\"": d_op = OP_dquote;
                        "G":  d_op = OP_G;
                        "K":  d_op = OP_K;
                        "k":  d_op = OP_k;
                        "M": begin d_emit = 1'b0; n_state = PS_M; end
                        "d": begin d_emit = 1'b0; n_state = PS_d; end
                        "r": begin d_emit = 1'b0; n_state = PS_r; end
                        "g": begin d_emit = 1'b0; n_state = PS_g; end
                        "c": begin d_emit = 1'b0; n_state = PS_c; end
                        "S": begin d_emit = 1'b0; n_state = PS_S; end
                        "s": begin d_emit = 1'b0; n_state = PS_s; end
                        "f": begin d_emit = 1'b0; n_state = PS_f; end
                        "B": begin d_emit = 1'b0; n_state = PS_B; end
                        "b": begin d_emit = 1'b0; n_state = PS_b; end
                        "W": begin d_emit = 1'b0; n_state = PS_W; end
                        "E": begin d_emit = 1'b0; n_state = PS_E; end
                        "T": begin d_emit = 1'b0; n_state = PS_T; end
                        "C": begin d_emit = 1'b0; n_state = PS_C; end
                        "R": begin d_emit = 1'b0; n_state = PS_R; end
                        "I": begin d_emit = 1'b0; n_state = PS_I; end
                        "D": begin d_emit = 1'b0; n_state = PS_D; end
                        default: d_status = ST_UNKNOWN;
                    endcase
                end
            end
            // optional longer form: shorter op on separator/end, byte not used
            PS_M, PS_g, PS_f, PS_b, PS_W, PS_SC, PS_sc: begin
                d_emit = 1'b1;
                if (ends) begin
                    case (r_state)
                        PS_M:    d_op = OP_M;
                        PS_g:    d_op = OP_g;
                        PS_f:    d_op = OP_f;
                        PS_b:    d_op = OP_b;
                        PS_W:    d_op = OP_W;
                        PS_SC:   d_op = OP_SC;
                        default: d_op = OP_sc;
                    endcase
                end else begin
                    d_used = 1'b1;
                    case (r_state)
                        PS_M:    if (r_in_byte == "P") d_op = OP_MP;
                                 else d_status = ST_UNKNOWN;
                        PS_g:    if (r_in_byte == "s") d_op = OP_gs;
                                 else d_status = ST_UNKNOWN;
                        PS_f:    if (r_in_byte == "*") d_op = OP_fstar;
                                 else d_status = ST_UNKNOWN;
                        PS_b:    if (r_in_byte == "*") d_op = OP_bstar;
                                 else d_status = ST_UNKNOWN;
                        PS_W:    if (r_in_byte == "*") d_op = OP_Wstar;
                                 else d_status = ST_UNKNOWN;
                        PS_SC:   if (r_in_byte == "N") d_op = OP_SCN;
                                 else d_status = ST_UNKNOWN;
                        default: if (r_in_byte == "n") d_op = OP_scn;
                                 else d_status = ST_UNKNOWN;
                    endcase
                    if (d_status != ST_OK) begin
                        d_used = 1'b0;
                    end
                end
            end
            PS_d, PS_c, PS_S, PS_s, PS_B: begin
                d_emit = 1'b1;
                if (ends) begin
                    case (r_state)
                        PS_d:    d_op = OP_d;
                        PS_c:    d_op = OP_c;
                        PS_S:    d_op = OP_S;
                        PS_s:    d_op = OP_s;
                        default: d_op = OP_B;
                    endcase
                end else begin
                    d_used   = 1'b1;
                    d_status = ST_UNKNOWN;
                    case (r_state)
                        PS_d: begin
                            if (r_in_byte == "0") begin d_op = OP_d0; d_status = ST_OK; end
                            if (r_in_byte == "1") begin d_op = OP_d1; d_status = ST_OK; end
                        end
                        PS_c: begin
                            if (r_in_byte == "m") begin d_op = OP_cm; d_status = ST_OK; end
                            if (r_in_byte == "s") begin d_op = OP_cs; d_status = ST_OK; end
                        end
                        PS_S: begin
                            if (r_in_byte == "C") begin d_emit = 1'b0; n_state = PS_SC; end
                        end
                        PS_s: begin
                            if (r_in_byte == "c") begin d_emit = 1'b0; n_state = PS_sc; end
                            if (r_in_byte == "h") begin d_op = OP_sh; d_status = ST_OK; end
                        end
                        default: begin
                            d_status = ST_OK;
                            case (r_in_byte)
                                "*": d_op = OP_Bstar;
                                "T": d_op = OP_BT;
                                "I": d_op = OP_BI;
                                "X": d_op = OP_BX;
                                "M": begin d_emit = 1'b0; n_state = PS_BM; end
                                "D": begin d_emit = 1'b0; n_state = PS_BD; end
                                default: d_status = ST_UNKNOWN;
                            endcase
                        end
                    endcase
                end
            end
            PS_r, PS_E, PS_T, PS_D, PS_BM, PS_BD, PS_EM, PS_C, PS_R, PS_I: begin
                d_emit = 1'b1;
                if (r_in_eod) begin
                    d_status = ST_EOD;
                end else begin
                    d_used   = 1'b1;
                    d_status = ST_OK;
                    case (r_state)
                        PS_r: begin
                            case (r_in_byte)
                                "i":     d_op = OP_ri;
                                "e":     d_op = OP_re;
                                "g":     d_op = OP_rg;
                                default: d_status = ST_UNKNOWN;
                            endcase
                        end
                        PS_E: begin
                            case (r_in_byte)
                                "T":     d_op = OP_ET;
                                "I":     d_op = OP_EI;
                                "X":     d_op = OP_EX;
                                "M":     begin d_emit = 1'b0; n_state = PS_EM; end
                                default: d_status = ST_UNKNOWN;
                            endcase
                        end
                        PS_T: begin
                            case (r_in_byte)
                                "c":     d_op = OP_Tc;
                                "w":     d_op = OP_Tw;
                                "z":     d_op = OP_Tz;
                                "L":     d_op = OP_TL;
                                "f":     d_op = OP_Tf;
                                "r":     d_op = OP_Tr;
                                "s":     d_op = OP_Ts;
                                "d":     d_op = OP_Td;
                                "D":     d_op = OP_TD;
                                "m":     d_op = OP_Tm;
                                "*":     d_op = OP_Tstar;
                                "j":     d_op = OP_Tj;
                                "J":     d_op = OP_TJ;
                                default: d_status = ST_UNKNOWN;
                            endcase
                        end
                        PS_D: begin
                            case (r_in_byte)
                                "o":     d_op = OP_Do;
                                "P":     d_op = OP_DP;
                                default: d_status = ST_UNKNOWN;
                            endcase
                        end
                        PS_BM:   if (r_in_byte == "C") d_op = OP_BMC;
                                 else d_status = ST_UNKNOWN;
                        PS_BD:   if (r_in_byte == "C") d_op = OP_BDC;
                                 else d_status = ST_UNKNOWN;
                        PS_EM:   if (r_in_byte == "C") d_op = OP_EMC;
                                 else d_status = ST_UNKNOWN;
                        PS_C:    if (r_in_byte == "S") d_op = OP_CS;
                                 else d_status = ST_UNKNOWN;
                        PS_R:    if (r_in_byte == "G") d_op = OP_RG;
                                 else d_status = ST_UNKNOWN;
                        default: if (r_in_byte == "D") d_op = OP_ID;
                                 else d_status = ST_UNKNOWN;
                    endcase
                end
            end
            default: n_state = PS_IDLE;
        endcase
        if (d_emit) begin
            n_state = PS_IDLE;
        end
        if (d_status != ST_OK) begin
            d_op = OP_w;
        end
    end

    assign out_free      = !r_out_valid || m_axis_tready;
    assign proc          = r_in_valid && (!d_emit || out_free);
    assign s_axis_tready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= PS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (proc) begin
                r_state <= n_state;
            end
            if (proc && d_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_eod  <= s_axis_tuser;
        end
        if (proc && d_emit) begin
            r_out_op     <= d_op;
            r_out_status <= d_status;
            r_out_used   <= d_used;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_op[OP_W_BITS-1:0]};
    assign m_axis_tuser  = {r_out_used, r_out_status};

endmodule

### src/csor_checker.sv
`include "assert_macros.svh"

module csor_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [2:0] m_axis_tuser
);
    import csor_pkg::*;

    logic [10:0] out_word;
    t_status     out_st;
    logic        st_legal;

    assign out_word = {m_axis_tuser, m_axis_tdata};
    assign out_st   = m_axis_tuser[1:0];
    assign st_legal = (out_st == ST_OK) || (out_st == ST_UNKNOWN) || (out_st == ST_EOD);

    `CSOR_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !m_axis_tvalid)
    `CSOR_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(out_word))
    `CSOR_ASSERT(a_err_zero_op, m_axis_tvalid && out_st != ST_OK |-> m_axis_tdata == 8'd0)
    `CSOR_ASSERT(a_eod_unused, m_axis_tvalid && out_st == ST_EOD |-> !m_axis_tuser[2])
    `CSOR_ASSERT(a_status_code, m_axis_tvalid |-> st_legal)

endmodule

bind content_stream_operator_recognizer_core csor_checker u_csor_checker (.*);
